// ----- hdl/lfpd_pkg.sv -----
// ---------------------------------------------------------------------------
// lfpd_pkg: shared types and constants
// Types, constants and the sequencer states of the line follower controller.
// ---------------------------------------------------------------------------
package lfpd_pkg;

  localparam int unsigned NUM_LINE_SENSORS_DEF = 6;
  localparam int unsigned RESET_WINDOW_DEF     = 3000;
  localparam int unsigned ERROR_FRAC_BITS_DEF  = 8;

  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned RAW_W     = 8;
  localparam int unsigned ERR_W     = 12;
  localparam int unsigned ESUM_W    = 24;
  localparam int unsigned TICK_W    = 12;
  localparam int unsigned NORM_W    = 10;
  localparam int unsigned PADDR_W   = 5;

  // register indexes
  localparam logic [2:0] REG_KP    = 3'd0;
  localparam logic [2:0] REG_KD    = 3'd1;
  localparam logic [2:0] REG_SLOW  = 3'd2;
  localparam logic [2:0] REG_FAST  = 3'd3;
  localparam logic [2:0] REG_LOST  = 3'd4;
  localparam logic [2:0] REG_WHITE = 3'd5;
  localparam logic [2:0] REG_STOP  = 3'd6;
  localparam logic [2:0] REG_STR   = 3'd7;

  localparam logic REQ_CAL  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [1:0] MARK_NONE  = 2'd0;
  localparam logic [1:0] MARK_LEFT  = 2'd1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] line_0, line_1, line_2, line_3, line_4, line_5;
    logic [7:0] wing_left, wing_right;
  } lfpd_in_t;

  typedef struct packed {
    logic              [7:0] left_fwd_duty;
    logic              [7:0] left_rev_duty;
    logic              [7:0] right_fwd_duty;
    logic              [7:0] right_rev_duty;
    logic                    stop_request;
    logic                    straight_seen;
    logic              [1:0] marker_code;
    logic                    line_lost;
    logic signed [ERR_W-1:0] line_error;
  } lfpd_out_t;

  typedef struct packed {
    logic [7:0]  kp;
    logic [7:0]  kd;
    logic [6:0]  slow_speed;
    logic [6:0]  fast_speed;
    logic [12:0] lost_threshold;
    logic [9:0]  white_threshold;
    logic [7:0]  stop_marker_count;
    logic [11:0] straight_min_ticks;
  } lfpd_cfg_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic busy;
  } lfpd_div_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NORM, ST_NDIV, ST_ERR, ST_EDIV, ST_UPD, ST_PD, ST_MDIV, ST_OUT
  } lfpd_state_e;

endpackage

// ----- hdl/lfpd_if.sv -----
// ---------------------------------------------------------------------------
// lfpd_stream_if: valid/ready channel
// Carries one payload with valid and ready between a source and a sink.
// ---------------------------------------------------------------------------
interface lfpd_stream_if #(parameter type T = logic) (input logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/lfpd_div.sv -----
// ---------------------------------------------------------------------------
// lfpd_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, shared by all quotients.
// ---------------------------------------------------------------------------
module lfpd_div
  import lfpd_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [W-1:0]        num_i,
  input  logic [W-1:0]        den_i,
  output lfpd_div_ctl_t       ctl_o,
  output logic [W-1:0]        quo_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    trial;

  // shift one numerator bit into the remainder per cycle
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[W-1]};
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
      cnt_d = CW'(W);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = W'(trial - {1'b0, den_q});
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = (cnt_q != '0) || start_i;
  assign quo_o       = quo_q;
endmodule

// ----- hdl/lfpd_regs.sv -----
// ---------------------------------------------------------------------------
// lfpd_regs: configuration registers
// APB-style register file for gains, speeds and thresholds.
// ---------------------------------------------------------------------------
module lfpd_regs
  import lfpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output lfpd_cfg_t          cfg_o
);
  lfpd_cfg_t  cfg_q;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp                 <= 8'd18;
      cfg_q.kd                 <= 8'd26;
      cfg_q.slow_speed         <= 7'd20;
      cfg_q.fast_speed         <= 7'd40;
      cfg_q.lost_threshold     <= 13'd1800;
      cfg_q.white_threshold    <= 10'd500;
      cfg_q.stop_marker_count  <= 8'd5;
      cfg_q.straight_min_ticks <= 12'd50;
    end else if (wr) begin
      unique case (idx)
        REG_KP:    cfg_q.kp                 <= pwdata[7:0];
        REG_KD:    cfg_q.kd                 <= pwdata[7:0];
        REG_SLOW:  cfg_q.slow_speed         <= pwdata[6:0];
        REG_FAST:  cfg_q.fast_speed         <= pwdata[6:0];
        REG_LOST:  cfg_q.lost_threshold     <= pwdata[12:0];
        REG_WHITE: cfg_q.white_threshold    <= pwdata[9:0];
        REG_STOP:  cfg_q.stop_marker_count  <= pwdata[7:0];
        REG_STR:   cfg_q.straight_min_ticks <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_KP:    prdata = {24'd0, cfg_q.kp};
      REG_KD:    prdata = {24'd0, cfg_q.kd};
      REG_SLOW:  prdata = {25'd0, cfg_q.slow_speed};
      REG_FAST:  prdata = {25'd0, cfg_q.fast_speed};
      REG_LOST:  prdata = {19'd0, cfg_q.lost_threshold};
      REG_WHITE: prdata = {22'd0, cfg_q.white_threshold};
      REG_STOP:  prdata = {24'd0, cfg_q.stop_marker_count};
      REG_STR:   prdata = {20'd0, cfg_q.straight_min_ticks};
      default:   prdata = '0;
    endcase
  end
endmodule

// ----- hdl/lfpd_core.sv -----
// ---------------------------------------------------------------------------
// lfpd_core: control sequencer
// Walks the sensors one slot a cycle unless dividing, shares one serial
// divider for normalization, line error and duty quotients and updates state.
// ---------------------------------------------------------------------------
module lfpd_core
  import lfpd_pkg::*;
#(
  parameter int unsigned NUM_LINE_SENSORS = NUM_LINE_SENSORS_DEF,
  parameter int unsigned RESET_WINDOW     = RESET_WINDOW_DEF,
  parameter int unsigned ERROR_FRAC_BITS  = ERROR_FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lfpd_cfg_t cfg_i,
  input  logic      in_valid_i,
  input  lfpd_in_t  in_data_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lfpd_out_t out_data_o
);
  localparam int unsigned LINES = (NUM_LINE_SENSORS > 6) ? 6 : NUM_LINE_SENSORS;
  localparam int unsigned F     = ERROR_FRAC_BITS;
  localparam int unsigned DW    = 32;
  localparam int signed   LIM   = 100 * (1 << F);
  localparam int signed   CENTER = (NUM_LINE_SENSORS - 1) * (1 << F);

  lfpd_state_e state_q, state_d;

  logic [RAW_W-1:0] min_q [NUM_SLOTS], max_q [NUM_SLOTS];
  logic [RAW_W-1:0] raw_q [NUM_SLOTS];
  logic             req_q;
  logic [1:0]       white_q;
  logic signed [ERR_W-1:0]  prev_q, e_q;
  logic signed [ESUM_W-1:0] esum_q;
  logic [TICK_W-1:0]        tick_q;
  logic [7:0]               rmc_q;
  logic [2:0]               slot_q;
  logic [15:0]              sum_q;
  logic [18:0]              wsum_q;
  logic [1:0]               code_q;
  logic                     lost_q, stop_q, straight_q;
  logic signed [31:0]       mot_q [2];
  logic                     mot_sel_q;
  logic [7:0]               duty_q [2];
  logic                     out_valid_q;
  lfpd_out_t                out_q;

  // divider
  logic          div_start;
  logic [DW-1:0] div_num, div_den, div_quo;
  lfpd_div_ctl_t div_ctl;

  lfpd_div #(.W(DW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .ctl_o(div_ctl), .quo_o(div_quo)
  );

  logic div_busy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_busy_q <= 1'b0;
    else         div_busy_q <= div_ctl.busy;
  end

  // current slot values
  logic [RAW_W-1:0] lo, hi, r;
  logic             deg, at_lo, at_hi;
  logic [NORM_W-1:0] direct_v;
  assign lo    = min_q[slot_q];
  assign hi    = max_q[slot_q];
  assign r     = raw_q[slot_q];
  assign deg   = hi <= lo;
  assign at_lo = r <= lo;
  assign at_hi = r >= hi;
  assign direct_v = deg ? NORM_W'(0) : (at_lo ? NORM_W'(0) : NORM_W'(1000));

  logic [NORM_W-1:0] norm_v;
  logic              need_div;
  assign need_div = !deg && !at_lo && !at_hi;
  assign norm_v   = (state_q == ST_NDIV) ? NORM_W'(div_quo) : direct_v;

  // line lost test on the finished sums
  logic lost_n;
  assign lost_n = (sum_q == '0) || (16'(cfg_i.lost_threshold) > sum_q);

  // PD arithmetic
  logic signed [ERR_W:0]   dlt;
  logic signed [31:0]      corr, base, ml, mr, mag_in, ecalc, mot_cur;
  logic signed [ESUM_W-1:0] esum_n;
  logic                    rst_win;
  logic [ESUM_W:0]         avg2;
  logic [31:0]             span;
  logic                    straight_n;
  assign dlt    = e_q - prev_q;
  assign corr   = $signed({24'd0, cfg_i.kp}) * 32'(e_q) + $signed({24'd0, cfg_i.kd}) * 32'(dlt);
  assign esum_n = esum_q + ESUM_W'(e_q);
  assign rst_win = (code_q == MARK_LEFT) || (tick_q > TICK_W'(RESET_WINDOW));
  assign avg2   = esum_n[ESUM_W-1] ? (ESUM_W+1)'(-{esum_n[ESUM_W-1], esum_n}) * 2'd2
                                   : (ESUM_W+1)'({1'b0, esum_n}) * 2'd2;
  assign span   = 32'(tick_q) << F;
  assign ecalc  = $signed(div_quo) - CENTER;
  // motor being divided: left first, then right
  assign mot_cur = mot_sel_q ? mr : ml;
  assign mag_in = mot_cur[31] ? -mot_cur : mot_cur;

  function automatic logic signed [31:0] clampm(input logic signed [31:0] v);
    if (v > LIM) return LIM;
    if (v < -LIM) return -LIM;
    return v;
  endfunction

  always_comb begin
    base = 32'(straight_q ? cfg_i.fast_speed : cfg_i.slow_speed) << F;
    ml   = clampm(base - corr);
    mr   = clampm(base + corr);
  end

  // handshake
  assign in_ready_o  = (state_q == ST_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next state and divider operands
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      ST_IDLE: if (in_valid_i && in_ready_o) begin
        state_d = (in_data_i.req_type == REQ_TICK) ? ST_NORM : ST_OUT;
      end
      ST_NORM: begin
        if (need_div) begin
          div_start = 1'b1;
          div_num   = DW'(r - lo) * 32'd1000;
          div_den   = DW'(hi - lo);
          state_d   = ST_NDIV;
        end else if (slot_q == 3'(LINES - 1)) begin
          state_d = ST_ERR;
        end
      end
      ST_NDIV: if (!div_ctl.busy && div_busy_q) begin
        state_d = (slot_q == 3'(LINES - 1)) ? ST_ERR : ST_NORM;
      end
      ST_ERR: begin
        if (!lost_n) begin
          div_start = 1'b1;
          div_num   = DW'(wsum_q) << (F + 1);
          div_den   = DW'(sum_q);
          state_d   = ST_EDIV;
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_EDIV: if (!div_ctl.busy && div_busy_q) state_d = ST_UPD;
      ST_UPD:  state_d = ST_PD;
      ST_PD: begin
        div_start = 1'b1;
        div_num   = DW'(mag_in) * 32'd255;
        div_den   = DW'(LIM);
        state_d   = ST_MDIV;
      end
      ST_MDIV: if (!div_ctl.busy && div_busy_q) state_d = mot_sel_q ? ST_OUT : ST_PD;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        min_q[i] <= '1;
        max_q[i] <= '0;
      end
      white_q <= '0;
      prev_q  <= '0;
      esum_q  <= '0;
      tick_q  <= TICK_W'(1);
      rmc_q   <= '0;
      slot_q  <= '0;
      mot_sel_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (in_valid_i && in_ready_o) begin
          req_q <= in_data_i.req_type;
          raw_q[0] <= in_data_i.line_0; raw_q[1] <= in_data_i.line_1;
          raw_q[2] <= in_data_i.line_2; raw_q[3] <= in_data_i.line_3;
          raw_q[4] <= in_data_i.line_4; raw_q[5] <= in_data_i.line_5;
          raw_q[6] <= in_data_i.wing_left; raw_q[7] <= in_data_i.wing_right;
          slot_q <= 3'd6;
          sum_q  <= '0;
          wsum_q <= '0;
          code_q <= MARK_NONE;
          stop_q <= 1'b0;
          mot_sel_q <= 1'b0;
        end
        ST_NORM, ST_NDIV: begin
          if ((state_q == ST_NORM && !need_div) ||
              (state_q == ST_NDIV && !div_ctl.busy && div_busy_q)) begin
            if (slot_q == 3'd6) begin
              white_q[0] <= norm_v < cfg_i.white_threshold;
              if ((norm_v < cfg_i.white_threshold) && !white_q[0]) code_q[0] <= 1'b1;
              slot_q <= 3'd7;
            end else if (slot_q == 3'd7) begin
              white_q[1] <= norm_v < cfg_i.white_threshold;
              if (!(norm_v < cfg_i.white_threshold) && white_q[1]) code_q[1] <= 1'b1;
              slot_q <= 3'd0;
            end else begin
              sum_q  <= sum_q + 16'(deg ? 10'd0 : 10'd1000 - norm_v);
              wsum_q <= wsum_q + 19'(slot_q) * 19'(deg ? 10'd0 : 10'd1000 - norm_v);
              slot_q <= slot_q + 3'd1;
            end
          end
        end
        ST_ERR: begin
          lost_q <= lost_n;
          if (lost_n) e_q <= prev_q;
        end
        ST_EDIV: if (!div_ctl.busy && div_busy_q) begin
          if (ecalc > 32'sd2047)       e_q <= 12'sd2047;
          else if (ecalc < -32'sd2048) e_q <= -12'sd2048;
          else                         e_q <= ERR_W'(ecalc);
        end
        ST_UPD: begin
          straight_q <= ((rst_win ? TICK_W'(1) : tick_q) > cfg_i.straight_min_ticks) &&
                        (rst_win ? 1'b1 : (32'(avg2) < span));
          esum_q <= rst_win ? '0 : esum_n;
          if (rst_win) tick_q <= TICK_W'(1);
          if (code_q[1]) begin
            if (rmc_q == cfg_i.stop_marker_count) begin
              stop_q <= 1'b1;
              rmc_q  <= '0;
            end else begin
              rmc_q <= rmc_q + 8'd1;
            end
          end
        end
        ST_PD: if (!mot_sel_q) begin
          mot_q[0] <= ml;
          mot_q[1] <= mr;
        end
        ST_MDIV: if (!div_ctl.busy && div_busy_q) begin
          duty_q[mot_sel_q] <= 8'(div_quo);
          mot_sel_q <= 1'b1;
        end
        ST_OUT: begin
          out_valid_q <= 1'b1;
          if (req_q == REQ_CAL) begin
            out_q <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (raw_q[i] > max_q[i]) max_q[i] <= raw_q[i];
              if (raw_q[i] < min_q[i]) min_q[i] <= raw_q[i];
            end
          end else begin
            out_q.left_fwd_duty  <= mot_q[0][31] ? 8'd0 : duty_q[0];
            out_q.left_rev_duty  <= mot_q[0][31] ? duty_q[0] : 8'd0;
            out_q.right_fwd_duty <= mot_q[1][31] ? 8'd0 : duty_q[1];
            out_q.right_rev_duty <= mot_q[1][31] ? duty_q[1] : 8'd0;
            out_q.stop_request   <= stop_q;
            out_q.straight_seen  <= straight_q;
            out_q.marker_code    <= code_q;
            out_q.line_lost      <= lost_q;
            out_q.line_error     <= e_q;
            prev_q <= e_q;
            tick_q <= tick_q + TICK_W'(1);
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- hdl/line_follower_pd_controller.sv -----
// ---------------------------------------------------------------------------
// line_follower_pd_controller: top level
// Line follower PD controller with sensor calibration and marker logic.
// ---------------------------------------------------------------------------
// Usage: items arrive on in_ch, one result per item leaves on out_ch; both
// are valid/ready channels and a transfer happens when both are high.
// A calibrate item widens the per-sensor min/max; its all-zero result is
// registered through state ST_OUT into the output register. A control tick
// normalizes eight sensors, through the bit-serial 32-step divider where
// the reading lies inside its span, divides once for the line error unless
// the line is lost, and once per motor duty. One item is in work at a time;
// the next is taken the cycle after the result has transferred. A stalled
// receiver holds the result in the output register. Reset restores the
// register defaults, min 255 and max 0 for all sensors, tick count 1 and
// clears the error and marker state at once. Registers sit on the APB-style
// port at byte address 4 * index.
// ---------------------------------------------------------------------------
module line_follower_pd_controller
  import lfpd_pkg::*;
#(
  parameter int unsigned NUM_LINE_SENSORS = NUM_LINE_SENSORS_DEF,
  parameter int unsigned RESET_WINDOW     = RESET_WINDOW_DEF,
  parameter int unsigned ERROR_FRAC_BITS  = ERROR_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lfpd_stream_if.sink        in_ch,
  lfpd_stream_if.source      out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  lfpd_cfg_t cfg;

  lfpd_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  lfpd_core #(
    .NUM_LINE_SENSORS(NUM_LINE_SENSORS),
    .RESET_WINDOW(RESET_WINDOW),
    .ERROR_FRAC_BITS(ERROR_FRAC_BITS)
  ) u_core (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .in_valid_i(in_ch.valid), .in_data_i(in_ch.data), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_o(out_ch.data)
  );
endmodule

// ----- hdl/lfpd_checker.sv -----
// ---------------------------------------------------------------------------
// lfpd_checker: port-level checks
// Assertions on the channels of the controller, bound to the top level.
// ---------------------------------------------------------------------------
module lfpd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  // held result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  // no new item taken while a result waits
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("accept while result pending");
  // a result never appears in the cycle after an accept
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
  // after an accept the input side is closed
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("double accept");
endmodule

bind line_follower_pd_controller lfpd_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
